// ===== sv/ltc_pkg.sv =====
// Package for the LRU image tile cache: sizes, codes, payload structs,
// sequencer state type. No dependencies.
package ltc_pkg;

  localparam int MAX_IMAGES = 16;
  localparam int MAX_TILES  = 1024;
  localparam int NUM_SLOTS  = 96;
  localparam int MAX_SPAN   = 8;

  localparam int ID_W      = $clog2(MAX_IMAGES);
  localparam int TILE_AW   = $clog2(MAX_TILES);
  localparam int MAP_DEPTH = MAX_IMAGES * MAX_TILES;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int SLOT_W    = 7;
  localparam int CNT_W     = $clog2(MAX_IMAGES) + 1;
  localparam int MAP_W     = 8;

  // Command codes
  localparam logic CMD_REGISTER = 1'b0;
  localparam logic CMD_SECTION  = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_TILE_W_LOG2 = 2'd0;
  localparam logic [1:0] REG_TILE_H_LOG2 = 2'd1;
  localparam logic [1:0] REG_SLOT_LIMIT  = 2'd2;

  typedef struct packed {
    logic        command;
    logic [31:0] image_key;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [3:0]  image_id;
    logic [15:0] region_x;
    logic [15:0] region_y;
    logic [15:0] region_w;
    logic [15:0] region_h;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  assigned_id;
    logic [6:0]  tile_slot;
    logic        hit;
    logic [15:0] tile_col;
    logic [15:0] tile_row;
    logic [15:0] first_col;
    logic [15:0] first_row;
    logic [2:0]  span_cols;
    logic [2:0]  span_rows;
    logic        last;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REG_SRCH,
    ST_REG_MUL,
    ST_REG_DEC,
    ST_SEC_CHK,
    ST_T_CHECK,
    ST_T_MUL,
    ST_T_ADDR,
    ST_MAP_RD,
    ST_MAP_DEC,
    ST_H_RD,
    ST_H_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_APPEND_OLD,
    ST_APPEND_NEW,
    ST_EV_RD,
    ST_EV_OWN,
    ST_EV_INV,
    ST_FILL,
    ST_EMIT
  } state_t;

endpackage

// ===== sv/ltc_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module ltc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lru_image_tile_cache.sv =====
// LRU image tile cache top level: sequencer, image table, shared multiplier.
// Depends on ltc_pkg and ltc_ram (tile map, slot owner and LRU order stores).
//
// Usage: req carries one transaction per command (register an image or
// request a section); rsp returns one or more results, the final one with
// last set. Both channels use valid/stall; a transaction moves when valid is
// high and stall is low. cfg_wen/cfg_index/cfg_data write the tile size
// and slot limit registers; write them only while the block is idle.
// Reset starts a clearing pass over the 16384-entry tile map, one entry per
// cycle; req_stall stays high until the pass is done.
// One command is handled at a time; req_stall is high until its last result
// has been loaded into the output register.
// Register searches the image table one entry at a time. A section is
// range checked, then each tile takes a fresh slot, a hit or an eviction;
// a hit searches and shifts the LRU order, an eviction shifts it, one entry
// at a time. Results leave through an output register, so a stalled
// receiver only holds the sequencer when the next result is ready and the
// register is still full.
module lru_image_tile_cache (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  ltc_pkg::req_t       req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output ltc_pkg::rsp_t       rsp,
  input  logic                cfg_wen,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_data
);
  import ltc_pkg::*;

  state_t state, state_next;

  // Configuration
  logic [3:0]  twl_cfg, thl_cfg;
  logic [6:0]  limit_cfg;
  logic [3:0]  twl, thl;
  logic [6:0]  limit_eff;

  // Image table
  logic [31:0] image_keys [MAX_IMAGES];
  logic [15:0] image_cols [MAX_IMAGES];
  logic [15:0] image_rows [MAX_IMAGES];
  logic [CNT_W-1:0] image_count;

  // Working registers
  req_t        req_q;
  rsp_t        res_q;
  logic [CNT_W-1:0] idx;
  logic [MAP_AW-1:0] clr_cnt;
  logic [15:0] cols_q, rows_q;
  logic [31:0] mul_q;
  logic [15:0] qx, qy;
  logic [2:0]  qw, qh, ci, cj;
  logic [16:0] col, row;
  logic [MAP_AW-1:0] addr_q;
  logic [6:0]  cur_slot;
  logic        hit_q;
  logic [6:0]  p;
  logic [6:0]  slots_used;

  // Combinational datapath
  logic [16:0] tmask_w, tmask_h, cols_c, rows_c;
  logic [16:0] qx_c, qy_c, qw_c, qh_c, ex_c, ey_c;
  logic [15:0] mul_a, mul_b;
  logic [15:0] id_cols, id_rows;
  logic [TILE_AW-1:0] tile_ofs;
  logic        fits_walk;

  // RAM ports
  logic              map_we;
  logic [MAP_AW-1:0] map_waddr, map_raddr;
  logic [MAP_W-1:0]  map_wdata, map_rdata;
  logic              own_we;
  logic [6:0]        own_waddr, own_raddr;
  logic [MAP_AW-1:0] own_wdata, own_rdata;
  logic              lru_we;
  logic [6:0]        lru_waddr, lru_raddr, lru_wdata, lru_rdata;

  logic out_free;
  logic [7:0] p_inc;

  ltc_ram #(.WIDTH(MAP_W), .DEPTH(MAP_DEPTH)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  ltc_ram #(.WIDTH(MAP_AW), .DEPTH(NUM_SLOTS)) u_owner (
    .clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
    .raddr(own_raddr), .rdata(own_rdata)
  );

  ltc_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_lru (
    .clk(clk), .we(lru_we), .waddr(lru_waddr), .wdata(lru_wdata),
    .raddr(lru_raddr), .rdata(lru_rdata)
  );

  // Effective configuration
  assign twl = (twl_cfg > 4'd8) ? 4'd8 : twl_cfg;
  assign thl = (thl_cfg > 4'd8) ? 4'd8 : thl_cfg;
  always_comb begin
    if (limit_cfg == 7'd0) begin
      limit_eff = 7'd1;
    end else if (limit_cfg > 7'(NUM_SLOTS)) begin
      limit_eff = 7'(NUM_SLOTS);
    end else begin
      limit_eff = limit_cfg;
    end
  end

  // Grid size by ceiling division, section span by shifts
  assign tmask_w = (17'd1 << twl) - 17'd1;
  assign tmask_h = (17'd1 << thl) - 17'd1;
  assign cols_c  = ({1'b0, req_q.image_width} + tmask_w) >> twl;
  assign rows_c  = ({1'b0, req_q.image_height} + tmask_h) >> thl;
  assign qx_c    = {1'b0, req_q.region_x} >> twl;
  assign qy_c    = {1'b0, req_q.region_y} >> thl;
  assign ex_c    = ({1'b0, req_q.region_x} + {1'b0, req_q.region_w}) >> twl;
  assign ey_c    = ({1'b0, req_q.region_y} + {1'b0, req_q.region_h}) >> thl;
  assign qw_c    = ex_c - qx_c;
  assign qh_c    = ey_c - qy_c;

  assign id_cols = image_cols[req_q.image_id];
  assign id_rows = image_rows[req_q.image_id];
  assign tile_ofs = mul_q[TILE_AW-1:0] + col[TILE_AW-1:0];
  assign fits_walk = (col < {1'b0, id_cols}) && (row < {1'b0, id_rows});
  assign p_inc = {1'b0, p} + 8'd1;

  // Shared multiplier operands
  always_comb begin
    if (state == ST_REG_MUL) begin
      mul_a = cols_q;
      mul_b = rows_q;
    end else begin
      mul_a = row[15:0];
      mul_b = id_cols;
    end
  end

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);

  // Next state and RAM controls
  always_comb begin
    state_next = state;
    map_we = 1'b0;
    map_waddr = addr_q;
    map_wdata = {1'b1, cur_slot};
    map_raddr = addr_q;
    own_we = 1'b0;
    own_waddr = cur_slot;
    own_wdata = addr_q;
    own_raddr = lru_rdata;
    lru_we = 1'b0;
    lru_waddr = p;
    lru_wdata = lru_rdata;
    lru_raddr = p;
    case (state)
      ST_CLEAR: begin
        map_we = 1'b1;
        map_waddr = clr_cnt;
        map_wdata = '0;
        if (clr_cnt == MAP_AW'(MAP_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (req.command == CMD_REGISTER) ? ST_REG_SRCH : ST_SEC_CHK;
        end
      end
      ST_REG_SRCH: begin
        if (idx == image_count) begin
          state_next = ST_REG_MUL;
        end else if (image_keys[idx[ID_W-1:0]] == req_q.image_key) begin
          state_next = ST_EMIT;
        end
      end
      ST_REG_MUL: state_next = ST_REG_DEC;
      ST_REG_DEC: state_next = ST_EMIT;
      ST_SEC_CHK: begin
        if (qw_c >= 17'(MAX_SPAN) || qh_c >= 17'(MAX_SPAN)) begin
          state_next = ST_EMIT;
        end else if ({1'b0, req_q.image_id} >= image_count) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_T_CHECK;
        end
      end
      ST_T_CHECK: state_next = fits_walk ? ST_T_MUL : ST_EMIT;
      ST_T_MUL: state_next = ST_T_ADDR;
      ST_T_ADDR: state_next = ST_MAP_RD;
      ST_MAP_RD: state_next = ST_MAP_DEC;
      ST_MAP_DEC: begin
        if (map_rdata[MAP_W-1]) begin
          state_next = ST_H_RD;
        end else if (slots_used >= limit_eff) begin
          state_next = ST_EV_RD;
        end else begin
          state_next = ST_APPEND_NEW;
        end
      end
      ST_H_RD: state_next = ST_H_CMP;
      ST_H_CMP: state_next = (lru_rdata == cur_slot) ? ST_SH_RD : ST_H_RD;
      ST_SH_RD: begin
        lru_raddr = p_inc[6:0];
        state_next = (p_inc < {1'b0, slots_used}) ? ST_SH_WR : ST_APPEND_OLD;
      end
      ST_SH_WR: begin
        lru_we = 1'b1;
        state_next = ST_SH_RD;
      end
      ST_APPEND_OLD: begin
        lru_we = 1'b1;
        lru_waddr = slots_used - 7'd1;
        lru_wdata = cur_slot;
        state_next = hit_q ? ST_EMIT : ST_FILL;
      end
      ST_APPEND_NEW: begin
        lru_we = 1'b1;
        lru_waddr = slots_used;
        lru_wdata = cur_slot;
        state_next = ST_FILL;
      end
      ST_EV_RD: begin
        lru_raddr = '0;
        state_next = ST_EV_OWN;
      end
      ST_EV_OWN: state_next = ST_EV_INV;
      ST_EV_INV: begin
        map_we = 1'b1;
        map_waddr = own_rdata;
        map_wdata = '0;
        state_next = ST_SH_RD;
      end
      ST_FILL: begin
        map_we = 1'b1;
        own_we = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = res_q.last ? ST_IDLE : ST_T_CHECK;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      twl_cfg <= 4'd8;
      thl_cfg <= 4'd8;
      limit_cfg <= 7'(NUM_SLOTS);
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_TILE_W_LOG2: twl_cfg <= cfg_data[3:0];
        REG_TILE_H_LOG2: thl_cfg <= cfg_data[3:0];
        REG_SLOT_LIMIT:  limit_cfg <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      image_count <= '0;
      slots_used <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + MAP_AW'(1);
      end
      if (state == ST_REG_DEC && image_count < CNT_W'(MAX_IMAGES)
          && mul_q <= 32'(MAX_TILES)) begin
        image_count <= image_count + CNT_W'(1);
      end
      if (state == ST_APPEND_NEW) begin
        slots_used <= slots_used + 7'd1;
      end
      if (state == ST_EMIT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mul_q <= 32'(mul_a) * 32'(mul_b);
    case (state)
      ST_IDLE: begin
        req_q <= req;
        idx <= '0;
      end
      ST_REG_SRCH: begin
        cols_q <= cols_c[15:0];
        rows_q <= rows_c[15:0];
        res_q <= '{status: STATUS_OK, assigned_id: idx[ID_W-1:0], last: 1'b1,
                   default: '0};
        if (idx != image_count) begin
          idx <= idx + CNT_W'(1);
        end
      end
      ST_REG_DEC: begin
        if (image_count >= CNT_W'(MAX_IMAGES) || mul_q > 32'(MAX_TILES)) begin
          res_q.status <= STATUS_FULL;
          res_q.assigned_id <= '0;
        end else begin
          image_keys[image_count[ID_W-1:0]] <= req_q.image_key;
          image_cols[image_count[ID_W-1:0]] <= cols_q;
          image_rows[image_count[ID_W-1:0]] <= rows_q;
          res_q.assigned_id <= image_count[ID_W-1:0];
        end
      end
      ST_SEC_CHK: begin
        qx <= qx_c[15:0];
        qy <= qy_c[15:0];
        qw <= qw_c[2:0];
        qh <= qh_c[2:0];
        ci <= '0;
        cj <= '0;
        col <= qx_c;
        row <= qy_c;
        res_q <= '{status: (qw_c >= 17'(MAX_SPAN) || qh_c >= 17'(MAX_SPAN))
                             ? STATUS_FULL : STATUS_RANGE,
                   first_col: qx_c[15:0],
                   first_row: qy_c[15:0],
                   span_cols: (qw_c > 17'd7) ? 3'd7 : qw_c[2:0],
                   span_rows: (qh_c > 17'd7) ? 3'd7 : qh_c[2:0],
                   last: 1'b1,
                   default: '0};
      end
      ST_T_CHECK: begin
        res_q.tile_col <= col[15:0];
        res_q.tile_row <= row[15:0];
        res_q.tile_slot <= '0;
        res_q.hit <= 1'b0;
        res_q.status <= fits_walk ? STATUS_OK : STATUS_RANGE;
        res_q.last <= fits_walk ? (ci == qh && cj == qw) : 1'b1;
      end
      ST_T_ADDR: begin
        addr_q <= {req_q.image_id, tile_ofs};
        p <= '0;
      end
      ST_MAP_DEC: begin
        hit_q <= map_rdata[MAP_W-1];
        cur_slot <= map_rdata[MAP_W-1] ? map_rdata[6:0] : slots_used;
      end
      ST_H_CMP: begin
        if (lru_rdata != cur_slot) begin
          p <= p + 7'd1;
        end
      end
      ST_SH_WR: p <= p + 7'd1;
      ST_APPEND_OLD: begin
        res_q.tile_slot <= cur_slot;
        res_q.hit <= hit_q;
      end
      ST_EV_OWN: cur_slot <= lru_rdata;
      ST_EV_INV: p <= '0;
      ST_FILL: res_q.tile_slot <= cur_slot;
      ST_APPEND_NEW: res_q.tile_slot <= cur_slot;
      ST_EMIT: begin
        if (out_free) begin
          rsp <= res_q;
          if (!res_q.last) begin
            if (cj == qw) begin
              cj <= '0;
              ci <= ci + 3'd1;
              col <= {1'b0, qx};
              row <= row + 17'd1;
            end else begin
              cj <= cj + 3'd1;
              col <= col + 17'd1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Checks
  a_slots_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= 7'(NUM_SLOTS))
    else $error("slot count beyond slot store");

  a_images_bound: assert property (@(posedge clk) disable iff (rst)
    image_count <= CNT_W'(MAX_IMAGES))
    else $error("image count beyond image table");

  a_clear_blocks: assert property (@(posedge clk)
    $past(rst) |-> req_stall)
    else $error("request taken during tile map clearing");

  a_used_within_limit_on_fill: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPEND_NEW) |-> (slots_used < limit_eff))
    else $error("fresh slot taken at or above the slot limit");

endmodule
